[rtl/capc_pkg.sv]
// Shared types and constants for the consumption-aware page cache.
package capc_pkg;

    localparam int CACHE_ENTRIES = 16;
    localparam int FILE_PAGES    = 4096;
    localparam int IDX_W         = $clog2(CACHE_ENTRIES);
    localparam int CNT_W         = $clog2(CACHE_ENTRIES + 1);
    localparam int PAGE_W        = 12;
    localparam int REC_W         = 14;
    localparam int HITS_W        = 16;
    localparam int SLOT_W        = 4;
    localparam int CAP_W         = 5;
    localparam int PIDX_W        = $clog2(FILE_PAGES);
    localparam int CLR_W         = PIDX_W + 1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SHIFT,
        ST_LOAD,
        ST_BUMP,
        ST_RETIRE,
        ST_OUT
    } capc_state_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_step;
        logic take;
        logic scan_step;
        logic decide;
        logic shift_step;
        logic load;
        logic bump;
        logic retire_step;
        logic retire_done;
        logic present;
    } capc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_done;
        logic scan_done;
        logic hit;
        logic shift_done;
        logic retire;
        logic retire_done;
        logic out_free;
    } capc_sts_t;

endpackage

[rtl/consumption_aware_page_cache_core.sv]
// Top level of the consumption-aware page cache: ports, capacity register, wiring.
//
// Channel   Direction  Transfer content
// s_axis    in         tdata: page_number[11:0], record_count[25:12], zero fill
// m_axis    out        tdata: hit[0], buffer_slot[4:1], evicted[5],
//                             evicted_page[17:6], retired[18], zero fill
// cfg       in         cfg_wdata: cache_capacity (5 bit)
//
// A request that hits passes from idle through the search, decide, bump, retire
// and output states; a miss adds the shift and load states, and a retirement
// closes the gap it leaves: the search, the shift and the retirement each
// move one entry a cycle. After reset a clearing pass zeroes all 4096 words
// of the saved-hits memory, with s_axis_tready low. One request is in flight at a time;
// a held result in the output register stalls only the next result.
module consumption_aware_page_cache_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // page_number, record_count
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // hit, buffer_slot, evicted, evicted_page, retired
);
    import capc_pkg::*;

    logic [CAP_W-1:0]  cap_reg;
    capc_cmd_t         cmd;
    capc_sts_t         sts;
    logic              o_hit, o_ev, o_ret;
    logic [SLOT_W-1:0] o_slot;
    logic [PAGE_W-1:0] o_evp;

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_W'(16);
        else if (cfg_we)
            cap_reg <= cfg_wdata;
    end

    capc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    capc_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cap         (cap_reg),
        .in_page     (s_axis_tdata[11:0]),
        .in_recs     (s_axis_tdata[25:12]),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_hit     (o_hit),
        .out_slot    (o_slot),
        .out_evicted (o_ev),
        .out_evpage  (o_evp),
        .out_retired (o_ret)
    );

    assign m_axis_tdata = {5'b0, o_ret, o_evp, o_ev, o_slot, o_hit};

endmodule

[rtl/capc_ctrl.sv]
// Sequencer for the page cache: clearing pass, search, shift, update, retirement, result.
module capc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  capc_pkg::capc_sts_t  sts,
    output capc_pkg::capc_cmd_t  cmd
);
    import capc_pkg::*;

    capc_state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = sts.hit ? ST_BUMP : ST_SHIFT;
            end
            ST_SHIFT:
            begin
                cmd.shift_step = 1'b1;
                if (sts.shift_done)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = ST_BUMP;
            end
            ST_BUMP:
            begin
                cmd.bump   = 1'b1;
                state_next = ST_RETIRE;
            end
            ST_RETIRE:
            begin
                if (!sts.retire || sts.retire_done)
                begin
                    cmd.retire_done = sts.retire;
                    state_next      = ST_OUT;
                end
                else
                    cmd.retire_step = 1'b1;
            end
            ST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.present = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

[rtl/capc_datapath.sv]
// Sorted entry table, saved-hits memory, victim search and result register.
module capc_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [capc_pkg::CAP_W-1:0]            cap,
    input  logic [capc_pkg::PAGE_W-1:0]           in_page,
    input  logic [capc_pkg::REC_W-1:0]            in_recs,
    input  capc_pkg::capc_cmd_t                   cmd,
    output capc_pkg::capc_sts_t                   sts,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  out_hit,
    output logic [capc_pkg::SLOT_W-1:0]           out_slot,
    output logic                                  out_evicted,
    output logic [capc_pkg::PAGE_W-1:0]           out_evpage,
    output logic                                  out_retired
);
    import capc_pkg::*;

    // Entry table, moved one position per cycle
    logic [PAGE_W-1:0] page_reg [CACHE_ENTRIES];
    logic [HITS_W-1:0] hits_reg [CACHE_ENTRIES];
    logic [HITS_W-1:0] recs_reg [CACHE_ENTRIES];
    logic [SLOT_W-1:0] slot_reg [CACHE_ENTRIES];
    logic [CNT_W-1:0]  used_reg;

    // Saved hits per page
    logic [HITS_W-1:0] saved_mem [FILE_PAGES];
    logic [HITS_W-1:0] saved_rd_reg;
    logic [CLR_W-1:0]  clr_reg;

    // Request and working registers
    logic [PAGE_W-1:0] rq_page_reg;
    logic [REC_W-1:0]  rq_recs_reg;
    logic [CNT_W-1:0]  scan_reg;
    logic [IDX_W-1:0]  x_reg;
    logic              xfound_reg;
    logic              hit_reg;
    logic [IDX_W-1:0]  vic_reg;
    logic [HITS_W-1:0] vdiff_reg;
    logic [IDX_W-1:0]  ptr_reg;
    logic [IDX_W-1:0]  stop_reg;
    logic              dir_up_reg;
    logic [SLOT_W-1:0] nslot_reg;
    logic              evicted_reg;
    logic [PAGE_W-1:0] evpage_reg;
    logic              retire_reg;
    logic [SLOT_W-1:0] rslot_reg;

    logic              ov_reg;
    logic              o_hit_reg, o_ev_reg, o_ret_reg;
    logic [SLOT_W-1:0] o_slot_reg;
    logic [PAGE_W-1:0] o_evp_reg;

    logic [CNT_W-1:0]  eff_cap;
    logic [IDX_W-1:0]  scan_idx;
    logic [HITS_W-1:0] scan_diff;
    logic              full;
    logic [HITS_W-1:0] bumped;
    logic [CNT_W-1:0]  x_ext;
    logic              sv_we;
    logic [PIDX_W-1:0] sv_addr;
    logic [HITS_W-1:0] sv_wd;

    always_comb
    begin
        if (cap == '0)
            eff_cap = CNT_W'(1);
        else if (cap > CAP_W'(CACHE_ENTRIES))
            eff_cap = CNT_W'(CACHE_ENTRIES);
        else
            eff_cap = CNT_W'(cap);
    end

    assign scan_idx  = scan_reg[IDX_W-1:0];
    assign scan_diff = recs_reg[scan_idx] - hits_reg[scan_idx];
    assign full      = used_reg >= eff_cap;
    assign bumped    = hits_reg[x_reg] + HITS_W'(1);
    // Insert position at full width: past the end when no larger page was found
    assign x_ext     = xfound_reg ? {1'b0, x_reg} : used_reg;

    // Saved-hits port: clearing pass, victim save, or nothing
    always_comb
    begin
        sv_we   = 1'b0;
        sv_addr = rq_page_reg[PIDX_W-1:0];
        sv_wd   = '0;
        if (cmd.clear_step)
        begin
            sv_we   = 1'b1;
            sv_addr = clr_reg[PIDX_W-1:0];
        end
        else if (cmd.decide && !hit_reg && full)
        begin
            sv_we   = 1'b1;
            sv_addr = page_reg[vic_reg][PIDX_W-1:0];
            sv_wd   = hits_reg[vic_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sv_we)
            saved_mem[sv_addr] <= sv_wd;
        saved_rd_reg <= saved_mem[rq_page_reg[PIDX_W-1:0]];
    end

    // Control and table registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            clr_reg  <= '0;
            ov_reg   <= 1'b0;
            for (int i = 0; i < CACHE_ENTRIES; i++)
                slot_reg[i] <= SLOT_W'(i);
        end
        else
        begin
            if (cmd.clear_step)
                clr_reg <= clr_reg + CLR_W'(1);
            if (cmd.present)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;

            if (cmd.take)
            begin
                rq_page_reg <= in_page;
                rq_recs_reg <= in_recs;
                scan_reg    <= '0;
                xfound_reg  <= 1'b0;
                x_reg       <= '0;
                vic_reg     <= '0;
                vdiff_reg   <= '1;
                hit_reg     <= 1'b0;
                evicted_reg <= 1'b0;
                evpage_reg  <= '0;
            end

            // Search: insert position, hit, and minimum remaining records
            if (cmd.scan_step && scan_reg < used_reg)
            begin
                if (!xfound_reg)
                begin
                    if (page_reg[scan_idx] >= rq_page_reg)
                    begin
                        xfound_reg <= 1'b1;
                        x_reg      <= scan_idx;
                        hit_reg    <= page_reg[scan_idx] == rq_page_reg;
                    end
                end
                if (scan_reg == '0 || scan_diff < vdiff_reg)
                begin
                    vdiff_reg <= scan_diff;
                    vic_reg   <= scan_idx;
                end
                scan_reg <= scan_reg + CNT_W'(1);
            end
            else if (cmd.scan_step && !xfound_reg)
                x_reg <= used_reg[IDX_W-1:0];

            // Plan the shift
            if (cmd.decide && !hit_reg)
            begin
                if (full)
                begin
                    evicted_reg <= 1'b1;
                    evpage_reg  <= page_reg[vic_reg];
                    nslot_reg   <= slot_reg[vic_reg];
                    if (x_ext > {1'b0, vic_reg})
                    begin
                        dir_up_reg <= 1'b1;
                        ptr_reg    <= vic_reg;
                        stop_reg   <= x_ext[IDX_W-1:0] - IDX_W'(1);
                        x_reg      <= x_ext[IDX_W-1:0] - IDX_W'(1);
                    end
                    else
                    begin
                        dir_up_reg <= 1'b0;
                        ptr_reg    <= vic_reg;
                        stop_reg   <= x_reg;
                    end
                end
                else
                begin
                    nslot_reg  <= slot_reg[used_reg[IDX_W-1:0]];
                    dir_up_reg <= 1'b0;
                    ptr_reg    <= used_reg[IDX_W-1:0];
                    stop_reg   <= x_reg;
                    used_reg   <= used_reg + CNT_W'(1);
                end
            end

            // One move per cycle
            if (cmd.shift_step && ptr_reg != stop_reg)
            begin
                if (dir_up_reg)
                begin
                    page_reg[ptr_reg] <= page_reg[ptr_reg + IDX_W'(1)];
                    hits_reg[ptr_reg] <= hits_reg[ptr_reg + IDX_W'(1)];
                    recs_reg[ptr_reg] <= recs_reg[ptr_reg + IDX_W'(1)];
                    slot_reg[ptr_reg] <= slot_reg[ptr_reg + IDX_W'(1)];
                    ptr_reg           <= ptr_reg + IDX_W'(1);
                end
                else
                begin
                    page_reg[ptr_reg] <= page_reg[ptr_reg - IDX_W'(1)];
                    hits_reg[ptr_reg] <= hits_reg[ptr_reg - IDX_W'(1)];
                    recs_reg[ptr_reg] <= recs_reg[ptr_reg - IDX_W'(1)];
                    slot_reg[ptr_reg] <= slot_reg[ptr_reg - IDX_W'(1)];
                    ptr_reg           <= ptr_reg - IDX_W'(1);
                end
            end

            // Place the new entry
            if (cmd.load)
            begin
                page_reg[x_reg] <= rq_page_reg;
                recs_reg[x_reg] <= {{(HITS_W-REC_W){1'b0}}, rq_recs_reg};
                slot_reg[x_reg] <= nslot_reg;
                hits_reg[x_reg] <= saved_rd_reg;
            end

            // Count the request
            if (cmd.bump)
            begin
                hits_reg[x_reg] <= bumped;
                retire_reg      <= bumped == recs_reg[x_reg];
                rslot_reg       <= slot_reg[x_reg];
                ptr_reg         <= x_reg;
                stop_reg        <= used_reg[IDX_W-1:0] - IDX_W'(1);
            end

            // Close the gap of a retired entry
            if (cmd.retire_step)
            begin
                page_reg[ptr_reg] <= page_reg[ptr_reg + IDX_W'(1)];
                hits_reg[ptr_reg] <= hits_reg[ptr_reg + IDX_W'(1)];
                recs_reg[ptr_reg] <= recs_reg[ptr_reg + IDX_W'(1)];
                slot_reg[ptr_reg] <= slot_reg[ptr_reg + IDX_W'(1)];
                ptr_reg           <= ptr_reg + IDX_W'(1);
            end
            if (cmd.retire_done)
            begin
                slot_reg[stop_reg] <= rslot_reg;
                used_reg           <= used_reg - CNT_W'(1);
            end

            // Result register
            if (cmd.present)
            begin
                o_hit_reg  <= hit_reg;
                o_slot_reg <= rslot_reg;
                o_ev_reg   <= evicted_reg;
                o_evp_reg  <= evpage_reg;
                o_ret_reg  <= retire_reg;
            end
        end
    end

    assign sts.clear_done  = clr_reg == CLR_W'(FILE_PAGES - 1);
    assign sts.scan_done   = scan_reg >= used_reg;
    assign sts.hit         = hit_reg;
    assign sts.shift_done  = ptr_reg == stop_reg;
    assign sts.retire      = retire_reg;
    assign sts.retire_done = ptr_reg == stop_reg;
    assign sts.out_free    = !ov_reg || out_ready;

    assign out_valid   = ov_reg;
    assign out_hit     = o_hit_reg;
    assign out_slot    = o_slot_reg;
    assign out_evicted = o_ev_reg;
    assign out_evpage  = o_evp_reg;
    assign out_retired = o_ret_reg;

endmodule

[tb/consumption_aware_page_cache_checker.sv]
// Checker for the page cache: watches the channels, predicts each result and compares.
module consumption_aware_page_cache_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    output int          pending,
    output int          fail_count
);
    import capc_pkg::*;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              evicted;
        logic [PAGE_W-1:0] ev_page;
        logic              retired;
    } lookup_t;

    // Cache mirror
    logic [CAP_W-1:0]  capacity;
    logic [PAGE_W-1:0] pg   [CACHE_ENTRIES];
    logic [HITS_W-1:0] hits [CACHE_ENTRIES];
    logic [REC_W-1:0]  recs [CACHE_ENTRIES];
    logic [SLOT_W-1:0] slt  [CACHE_ENTRIES];
    int                used;
    logic [HITS_W-1:0] saved [FILE_PAGES];
    lookup_t           lookups_due [$];

    function automatic void move_entry(int dst, int src);
        pg[dst]   = pg[src];
        hits[dst] = hits[src];
        recs[dst] = recs[src];
        slt[dst]  = slt[src];
    endfunction

    function automatic lookup_t cache_lookup(logic [PAGE_W-1:0] page, logic [REC_W-1:0] rc);
        lookup_t           r;
        int                x;
        int                v;
        int                cap;
        logic [HITS_W-1:0] d;
        logic [HITS_W-1:0] best;
        logic [SLOT_W-1:0] s;
        r = '0;
        x = 0;
        cap = (capacity == 0) ? 1 : (capacity > CACHE_ENTRIES) ? CACHE_ENTRIES : capacity;
        while (x < used && pg[x] < page)
            x++;
        r.hit = (x < used && pg[x] == page);
        if (!r.hit)
        begin
            if (used >= cap)
            begin
                // victim: fewest records left unread, first wins a tie
                v = 0;
                best = HITS_W'(recs[0]) - hits[0];
                for (int i = 1; i < used; i++)
                begin
                    d = HITS_W'(recs[i]) - hits[i];
                    if (d < best)
                    begin
                        best = d;
                        v = i;
                    end
                end
                r.evicted = 1'b1;
                r.ev_page = pg[v];
                saved[pg[v]] = hits[v];
                s = slt[v];
                if (x > v)
                begin
                    for (int i = v; i + 1 < x; i++)
                        move_entry(i, i + 1);
                    x--;
                end
                else
                    for (int i = v; i > x; i--)
                        move_entry(i, i - 1);
            end
            else
            begin
                s = slt[used];
                for (int i = used; i > x; i--)
                    move_entry(i, i - 1);
                used++;
            end
            pg[x]   = page;
            recs[x] = rc;
            slt[x]  = s;
            hits[x] = saved[page];
        end
        hits[x] = hits[x] + 1'b1;
        r.slot = slt[x];
        if (hits[x] == HITS_W'(recs[x]))
        begin
            r.retired = 1'b1;
            s = slt[x];
            for (int i = x; i + 1 < used; i++)
                move_entry(i, i + 1);
            used--;
            slt[used] = s;
        end
        return r;
    endfunction

    assign pending = lookups_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        lookup_t want;
        lookup_t got;
        if (!rst_n)
        begin
            capacity = 5'd16;
            used = 0;
            fail_count = 0;
            lookups_due.delete();
            for (int i = 0; i < CACHE_ENTRIES; i++)
            begin
                pg[i] = '0;
                hits[i] = '0;
                recs[i] = '0;
                slt[i] = SLOT_W'(i);
            end
            for (int i = 0; i < FILE_PAGES; i++)
                saved[i] = '0;
        end
        else
        begin
            if (cfg_we)
                capacity = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                lookups_due.push_back(cache_lookup(s_axis_tdata[11:0], s_axis_tdata[25:12]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tdata[0], m_axis_tdata[4:1], m_axis_tdata[5],
                       m_axis_tdata[17:6], m_axis_tdata[18]};
                if (lookups_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transfer %h", m_axis_tdata);
                end
                else
                begin
                    want = lookups_due.pop_front();
                    if (got !== want || m_axis_tdata[23:19] !== '0)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: hit %b/%b slot %0d/%0d evicted %b/%b",
                                      " page %0d/%0d retired %b/%b"},
                                     want.hit, got.hit, want.slot, got.slot, want.evicted,
                                     got.evicted, want.ev_page, got.ev_page, want.retired,
                                     got.retired);
                    end
                end
            end
        end
    end

endmodule

[tb/consumption_aware_page_cache_core_test.sv]
// Testbench top for the page cache: stimulus, stalls, configuration and verdict.
module consumption_aware_page_cache_core_test;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [4:0]  cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    int          pending;
    int          fail_count;
    int          cycles = 0;
    int          gap_max = 15;
    logic [11:0] page_pool [24];

    always #6 clk = ~clk;

    consumption_aware_page_cache_core i_dut (.*);

    consumption_aware_page_cache_checker i_check (.*);

    // Run guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 600000)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Result side stalls
    initial
    begin
        @(posedge clk iff rst_n);
        forever
        begin
            if (gap_max > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, gap_max)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_request(logic [11:0] page, logic [13:0] rc);
        if (gap_max > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(0, gap_max)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, rc, page};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic set_capacity(logic [4:0] cap);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Random phase: mostly a small page pool so hits, evictions and retirements recur
    task automatic random_phase(int n);
        logic [11:0] page;
        logic [13:0] rc;
        for (int i = 0; i < 24; i++)
            page_pool[i] = 12'($urandom);
        for (int i = 0; i < n; i++)
        begin
            page = ($urandom_range(0, 9) == 0) ? 12'($urandom) : page_pool[$urandom_range(0, 23)];
            case ($urandom_range(0, 9))
                0:       rc = 14'($urandom);
                1:       rc = 14'd0;
                default: rc = 14'($urandom_range(1, 8));
            endcase
            send_request(page, rc);
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, immediate retirement, hits, capacity one
        send_request(12'd0, 14'd1);
        send_request(12'd4095, 14'd16383);
        send_request(12'd4095, 14'd16383);
        send_request(12'd7, 14'd3);
        send_request(12'd7, 14'd3);
        send_request(12'd7, 14'd3);
        send_request(12'd100, 14'd0);
        send_request(12'd2048, 14'd2);
        send_request(12'd1365, 14'd10922);
        send_request(12'd2730, 14'd5461);
        set_capacity(5'd1);
        send_request(12'd50, 14'd5);
        send_request(12'd60, 14'd5);
        send_request(12'd50, 14'd5);
        send_request(12'd4095, 14'd16383);
        set_capacity(5'd0);
        send_request(12'd9, 14'd2);
        send_request(12'd10, 14'd4);
        set_capacity(5'd31);
        send_request(12'd11, 14'd4);
        send_request(12'd10, 14'd4);

        // Random phases over several capacities, one without idling
        random_phase(250);
        set_capacity(5'd4);
        random_phase(250);
        set_capacity(5'd2);
        gap_max = 0;
        random_phase(150);
        gap_max = 15;
        set_capacity(5'd16);
        random_phase(250);
        set_capacity(5'd1);
        random_phase(100);
        set_capacity(5'd8);
        random_phase(200);

        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
